>>> sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is asserted.
`define NSD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that also holds during reset.
`define NSD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/nsd_pkg.sv
`default_nettype none

package nsd_pkg;

  localparam int unsigned POSITIONS   = 16;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned IDX_W  = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int unsigned CNT_W  = $clog2(POSITIONS + 1);
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(POSITIONS);
  localparam int unsigned SQ_W   = 2 * SAMPLE_BITS;
  localparam int unsigned SSUM_W = SQ_W + $clog2(POSITIONS);
  localparam int unsigned DIV_W  = SSUM_W;
  localparam int unsigned ROOT_W = (SSUM_W + 1) / 2;
  localparam int unsigned DEV_W  = 16;
  localparam logic [DEV_W-1:0] DEV_MAX = {DEV_W{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_SCAN,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT
  } nsd_state_e;

endpackage

`default_nettype wire

>>> sv/nsd_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. Used for the mean and the variance.
module nsd_div import nsd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DIV_W-1:0]      quotient_o
);

  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_sub;
  logic              fits;

  always_comb begin
    trial     = {rem_q, quo_q[DIV_W-1]};
    trial_sub = trial - {1'b0, dvs_q};
    fits      = (trial >= {1'b0, dvs_q});
    rem_d     = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    quo_d     = {quo_q[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> sv/nsd_sqrt.sv
`default_nettype none

// Digit-by-digit floor square root, one root bit per cycle.
module nsd_sqrt import nsd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [2*ROOT_W-1:0] radicand_i,
  output logic                     done_o,
  output logic [ROOT_W-1:0]        root_o
);

  localparam int unsigned STEP_W = $clog2(ROOT_W + 1);

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   step_q;
  logic [2*ROOT_W-1:0] x_q;
  logic [ROOT_W+1:0]   rem_q, rem_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [ROOT_W+3:0]   rem_sh;
  logic [ROOT_W+3:0]   trial;
  logic [ROOT_W+3:0]   rem_sub;
  logic                fits;

  always_comb begin
    rem_sh  = {rem_q, x_q[2*ROOT_W-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    rem_sub = rem_sh - trial;
    fits    = (rem_sh >= trial);
    rem_d   = fits ? rem_sub[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
    root_d  = {root_q[ROOT_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[2*ROOT_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

>>> sv/nonzero_std_deviation.sv
`default_nettype none

// Channel   Direction  Signals                          Handshake
// request   in         sample_i                         start_i & !busy_o
// result    out        deviation_o, all_zero_o          done_o, one cycle
//
// Samples load one per cycle while busy_o is low. The last sample of a set with
// a nonzero sample raises busy_o; the set then goes through the bit-serial divider,
// which runs twice, and the root unit. A set of all zeros gives its result in
// the cycle after the last sample.
// Reset clears the set in progress; the sample store needs no clearing.
// The result cannot be stalled: done_o is high for exactly one cycle.
module nonzero_std_deviation import nsd_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [DEV_W-1:0]            deviation_o,
  output logic                        all_zero_o
);

  nsd_state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] mem [POSITIONS];

  logic [IDX_W-1:0]       ld_idx_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SSUM_W-1:0]      ssum_q;
  logic [CNT_W-1:0]       issue_q;
  logic                   v1_q, v2_q, v3_q;
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [SAMPLE_BITS-1:0] diff_q;
  logic [SQ_W-1:0]        sq_q;
  logic [SAMPLE_BITS-1:0] mean_q;
  logic [DIV_W-1:0]       var_q;
  logic                   done_q;
  logic [DEV_W-1:0]       dev_q;
  logic                   az_q;

  logic                   accept;
  logic                   last;
  logic                   sample_nz;
  logic                   scan_en;
  logic                   scan_done;
  logic                   div_start;
  logic [DIV_W-1:0]       div_dividend;
  logic                   div_done;
  logic [DIV_W-1:0]       div_quo;
  logic                   sqrt_start;
  logic                   sqrt_done;
  logic [ROOT_W-1:0]      root;
  logic [63:0]            root_ext;

  assign accept    = start_i && !busy_o;
  assign last      = (ld_idx_q == IDX_W'(POSITIONS - 1));
  assign sample_nz = |sample_i;
  assign sum_d     = sum_q + (sample_nz ? SUM_W'(sample_i) : '0);
  assign cnt_d     = cnt_q + (sample_nz ? CNT_W'(1) : '0);
  assign scan_done = (issue_q == CNT_W'(POSITIONS)) && !v1_q && !v2_q && !v3_q;
  assign root_ext  = 64'(root);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept && last && (cnt_d != '0)) state_d = ST_MEAN_GO;
      end
      ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (div_done) state_d = ST_SCAN;
      ST_SCAN:      if (scan_done) state_d = ST_VAR_GO;
      ST_VAR_GO:    state_d = ST_VAR_WAIT;
      ST_VAR_WAIT:  if (div_done) state_d = ST_ROOT_GO;
      ST_ROOT_GO:   state_d = ST_ROOT_WAIT;
      ST_ROOT_WAIT: if (sqrt_done) state_d = ST_LOAD;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy_o       = 1'b1;
    div_start    = 1'b0;
    div_dividend = ssum_q;
    sqrt_start   = 1'b0;
    scan_en      = 1'b0;
    unique case (state_q)
      ST_LOAD:    busy_o = 1'b0;
      ST_MEAN_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(sum_q);
      end
      ST_SCAN:    scan_en = (issue_q != CNT_W'(POSITIONS));
      ST_VAR_GO:  div_start = 1'b1;
      ST_ROOT_GO: sqrt_start = 1'b1;
      ST_MEAN_WAIT, ST_VAR_WAIT, ST_ROOT_WAIT: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Sample store.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[ld_idx_q] <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_en) begin
      rd_q <= mem[issue_q[IDX_W-1:0]];
    end
  end

  // Control counters and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_idx_q <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      ssum_q   <= '0;
      issue_q  <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      v1_q   <= scan_en;
      v2_q   <= v1_q && (rd_q != '0);
      v3_q   <= v2_q;
      if (accept) begin
        ld_idx_q <= last ? '0 : ld_idx_q + IDX_W'(1);
        if (last && (cnt_d == '0)) begin
          sum_q  <= '0;
          cnt_q  <= '0;
          done_q <= 1'b1;
        end else begin
          sum_q <= sum_d;
          cnt_q <= cnt_d;
        end
      end
      if (state_q == ST_MEAN_GO) begin
        ssum_q  <= '0;
        issue_q <= '0;
      end else begin
        if (scan_en) issue_q <= issue_q + CNT_W'(1);
        if (v3_q) ssum_q <= ssum_q + SSUM_W'(sq_q);
      end
      if ((state_q == ST_ROOT_WAIT) && sqrt_done) begin
        sum_q  <= '0;
        cnt_q  <= '0;
        done_q <= 1'b1;
      end
    end
  end

  // Squared-deviation pipeline and result payload.
  always_ff @(posedge clk_i) begin
    diff_q <= (rd_q >= mean_q) ? (rd_q - mean_q) : (mean_q - rd_q);
    sq_q   <= SQ_W'(diff_q) * SQ_W'(diff_q);
    if ((state_q == ST_MEAN_WAIT) && div_done) begin
      mean_q <= div_quo[SAMPLE_BITS-1:0];
    end
    if ((state_q == ST_VAR_WAIT) && div_done) begin
      var_q <= div_quo;
    end
    if (accept && last && (cnt_d == '0)) begin
      dev_q <= '0;
      az_q  <= 1'b1;
    end else if ((state_q == ST_ROOT_WAIT) && sqrt_done) begin
      dev_q <= (root_ext > 64'(DEV_MAX)) ? DEV_MAX : root_ext[DEV_W-1:0];
      az_q  <= 1'b0;
    end
  end

  nsd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  nsd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i ((2*ROOT_W)'(var_q)),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  assign done_o      = done_q;
  assign deviation_o = dev_q;
  assign all_zero_o  = az_q;

endmodule

`default_nettype wire

>>> sv/nsd_checker.sv
`default_nettype none

`include "assert_macros.svh"

module nsd_checker import nsd_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   start_i,
  input wire logic [SAMPLE_BITS-1:0] sample_i,
  input wire logic                   busy_o,
  input wire logic                   done_o,
  input wire logic [DEV_W-1:0]       deviation_o,
  input wire logic                   all_zero_o
);

  logic unused_sample;
  assign unused_sample = ^sample_i;

  // Reset leaves the block idle with no result pending.
  `NSD_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (!done_o && !busy_o), "not idle in reset")
  // A result never appears while a set is still being worked on.
  `NSD_ASSERT(a_done_not_busy, clk_i, rst_ni, !(done_o && busy_o), "result while busy")
  // The block only goes busy after taking the last request of a set.
  `NSD_ASSERT(a_busy_after_req, clk_i, rst_ni, $rose(busy_o) |-> $past(start_i), "no request")
  // Every busy period ends with its result.
  `NSD_ASSERT(a_busy_ends_done, clk_i, rst_ni, $fell(busy_o) |-> done_o, "no result at end")
  // An all-zero set reports a zero deviation.
  `NSD_ASSERT(a_zero_dev, clk_i, rst_ni, done_o && all_zero_o |-> deviation_o == '0, "bad zero set")

endmodule

bind nonzero_std_deviation nsd_checker u_nsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .sample_i    (sample_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .deviation_o (deviation_o),
  .all_zero_o  (all_zero_o)
);

`default_nettype wire
